// ----- rtl/tkd_pkg.sv -----
package tkd_pkg;

   localparam int MAX_KEYS_DEF     = 16;
   localparam int CAL_SAMPLES_DEF  = 8;
   localparam int RELEASE_HOLD_DEF = 10;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 3;
   localparam int KEY_ID_W   = 4;
   localparam int VALUE_W    = 16;
   localparam int SUM_W      = 24;
   localparam int DEB_W      = 8;
   localparam int PHASE_W    = 2;
   localparam int ROUND_W    = 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int KEY_COUNT_W = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_COUNT       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_LIMIT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASELINE_PERIOD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOUCH_DELTA     = 2'd3;

   localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RST       = 5'd16;
   localparam logic [CSR_DATA_W-1:0]  DEBOUNCE_LIMIT_RST  = 8'd3;
   localparam logic [CSR_DATA_W-1:0]  BASELINE_PERIOD_RST = 8'd10;
   localparam logic [CSR_DATA_W-1:0]  TOUCH_DELTA_RST     = 8'd26;

   localparam logic [RSP_USER_W-1:0] EV_IDLE       = 3'd0;
   localparam logic [RSP_USER_W-1:0] EV_TOUCH      = 3'd1;
   localparam logic [RSP_USER_W-1:0] EV_TOUCHED    = 3'd2;
   localparam logic [RSP_USER_W-1:0] EV_RELEASE    = 3'd3;
   localparam logic [RSP_USER_W-1:0] EV_RELEASED   = 3'd4;
   localparam logic [RSP_USER_W-1:0] EV_TIMEOUT    = 3'd5;
   localparam logic [RSP_USER_W-1:0] EV_CALIBRATED = 3'd6;

   localparam int DIV_W     = 24;
   localparam int DIVISOR_W = 8;
   localparam int DIV_CNT_W = 5;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [DEB_W-1:0]   deb_count;
      logic [VALUE_W-1:0] base;
      logic [SUM_W-1:0]   sum;
   } key_rec_type;

   typedef struct packed {
      logic load;
      logic capture;
      logic div_start;
      logic div_long;
      logic upd_capture;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic is_cal;
      logic tmo;
      logic cal_last;
      logic div_busy;
      logic rem_zero;
      logic out_free;
   } sts_type;

endpackage

// ----- rtl/tkd_ram.sv -----
module tkd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tkd_div.sv -----
module tkd_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           long_mode,
   input  logic [tkd_pkg::DIV_W-1:0]      dividend,
   input  logic [tkd_pkg::DIVISOR_W-1:0]  divisor,
   output logic                           busy,
   output logic [tkd_pkg::DIV_W-1:0]      quotient,
   output logic [tkd_pkg::DIVISOR_W-1:0]  remainder
);

   localparam int DW = tkd_pkg::DIV_W;
   localparam int SW = tkd_pkg::DIVISOR_W;
   localparam int CW = tkd_pkg::DIV_CNT_W;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] dsr_ff;
   logic [SW:0]   trial;
   logic          fits;

   always_comb begin
      trial  = {rem_ff, dvd_ff[DW-1]};
      fits   = trial >= {1'b0, dsr_ff};
      rem_in = fits ? SW'(trial - {1'b0, dsr_ff}) : trial[SW-1:0];
      dvd_in = {dvd_ff[DW-2:0], fits};
      if (start) begin
         cnt_in = long_mode ? CW'(DW) : CW'(SW);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CW'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= long_mode ? dividend : {dividend[SW-1:0], {(DW-SW){1'b0}}};
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (cnt_ff != '0) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign busy      = cnt_ff != '0;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/tkd_ctrl.sv -----
module tkd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  tkd_pkg::sts_type sts,
   output tkd_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_RDIV = 3'd2;
   localparam logic [2:0] ST_QDIV = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.capture = 1'b1;
            if (sts.tmo) begin
               state_in = ST_DONE;
            end else if (sts.is_cal) begin
               if (sts.cal_last) begin
                  cmd.div_start = 1'b1;
                  cmd.div_long  = 1'b1;
                  state_in      = ST_QDIV;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_RDIV;
            end
         end
         ST_RDIV: begin
            if (!sts.div_busy) begin
               cmd.upd_capture = 1'b1;
               if (sts.rem_zero) begin
                  cmd.div_start = 1'b1;
                  cmd.div_long  = 1'b1;
                  state_in      = ST_QDIV;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_QDIV: begin
            if (!sts.div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;

endmodule

// ----- rtl/tkd_dp.sv -----
module tkd_dp #(
   parameter int MAX_KEYS     = tkd_pkg::MAX_KEYS_DEF,
   parameter int CAL_SAMPLES  = tkd_pkg::CAL_SAMPLES_DEF,
   parameter int RELEASE_HOLD = tkd_pkg::RELEASE_HOLD_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tkd_pkg::cmd_type                   cmd,
   output tkd_pkg::sts_type                   sts,
   input  logic [tkd_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [tkd_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tkd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [tkd_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tkd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tkd_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int KW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CCW   = $clog2(CAL_SAMPLES + 1);
   localparam int CSW   = tkd_pkg::VALUE_W + $clog2(CAL_SAMPLES);
   localparam int REC_W = $bits(tkd_pkg::key_rec_type);
   localparam int VW    = tkd_pkg::VALUE_W;
   localparam int SUMW  = tkd_pkg::SUM_W;
   localparam int DW    = tkd_pkg::DEB_W;
   localparam int RW    = tkd_pkg::ROUND_W;
   localparam int EW    = tkd_pkg::RSP_USER_W;
   localparam int PRODW = VW + tkd_pkg::CSR_DATA_W + 1;

   localparam logic [tkd_pkg::PHASE_W-1:0] PH_IDLE     = 2'd0;
   localparam logic [tkd_pkg::PHASE_W-1:0] PH_TOUCHED  = 2'd1;
   localparam logic [tkd_pkg::PHASE_W-1:0] PH_RELEASED = 2'd2;

   // configuration
   logic [tkd_pkg::KEY_COUNT_W-1:0] key_count_ff;
   logic [7:0] debounce_limit_ff, baseline_period_ff, touch_delta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff       <= tkd_pkg::KEY_COUNT_RST;
         debounce_limit_ff  <= tkd_pkg::DEBOUNCE_LIMIT_RST;
         baseline_period_ff <= tkd_pkg::BASELINE_PERIOD_RST;
         touch_delta_ff     <= tkd_pkg::TOUCH_DELTA_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            tkd_pkg::CSR_KEY_COUNT:       key_count_ff <= csr_data[tkd_pkg::KEY_COUNT_W-1:0];
            tkd_pkg::CSR_DEBOUNCE_LIMIT:  debounce_limit_ff  <= csr_data;
            tkd_pkg::CSR_BASELINE_PERIOD: baseline_period_ff <= csr_data;
            tkd_pkg::CSR_TOUCH_DELTA:     touch_delta_ff     <= csr_data;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   logic [7:0] kc;
   logic [7:0] period_eff;

   always_comb begin
      if (key_count_ff == '0) begin
         kc = 8'd1;
      end else if (8'(key_count_ff) > 8'(MAX_KEYS)) begin
         kc = 8'(MAX_KEYS);
      end else begin
         kc = 8'(key_count_ff);
      end
      period_eff = (baseline_period_ff == '0) ? 8'd1 : baseline_period_ff;
   end

   // scan and calibration state
   logic [KW-1:0]  scan_key_ff, cal_key_ff;
   logic [RW-1:0]  round_ff;
   logic [CCW-1:0] cal_count_ff;
   logic [CSW-1:0] cal_sum_ff;
   logic [MAX_KEYS-1:0] valid_ff;

   // request capture
   logic           req_cal, req_self, req_tmo;
   logic [VW-1:0]  sense_in;
   logic           scan_wrap, cal_wrap;
   logic [KW-1:0]  key_in;
   logic [RW-1:0]  round_eff_in;

   logic           is_cal_ff, tmo_ff;
   logic [VW-1:0]  sense_ff;
   logic [KW-1:0]  key_ff;
   logic [RW-1:0]  round_eff_ff;

   always_comb begin
      req_cal      = req_tuser[0];
      req_self     = req_tuser[1];
      req_tmo      = req_tuser[2];
      sense_in     = req_self ? ~req_tdata : req_tdata;
      scan_wrap    = 8'(scan_key_ff) >= kc;
      cal_wrap     = 8'(cal_key_ff) >= kc;
      round_eff_in = scan_wrap ? round_ff + RW'(1) : round_ff;
      if (req_cal) begin
         key_in = cal_wrap ? '0 : cal_key_ff;
      end else begin
         key_in = scan_wrap ? '0 : scan_key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_cal_ff    <= req_cal;
         tmo_ff       <= req_tmo;
         sense_ff     <= sense_in;
         key_ff       <= key_in;
         round_eff_ff <= round_eff_in;
      end
   end

   // key table
   logic                 wr_en;
   logic [REC_W-1:0]     rd_data;
   tkd_pkg::key_rec_type rec, new_rec, rec_ff;

   tkd_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_KEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (key_ff),
      .wr_data (new_rec),
      .rd_en   (cmd.load),
      .rd_addr (key_in),
      .rd_data (rd_data)
   );

   logic [SUMW:0]  sum_wide;
   logic [PRODW-1:0] prod;
   logic [SUMW-1:0] sum_ff;
   logic [VW:0]    thr_ff;
   logic           update_ff;

   always_comb begin
      rec      = valid_ff[key_ff] ? tkd_pkg::key_rec_type'(rd_data) : '0;
      sum_wide = {1'b0, rec.sum} + (SUMW+1)'(sense_ff);
      prod     = PRODW'(rec.base) * PRODW'({1'b1, touch_delta_ff});
   end

   // divider shared by round phase, averaging and calibration
   logic                          cal_first, cal_last;
   logic [CSW-1:0]                cal_total;
   logic [tkd_pkg::DIV_W-1:0]     div_dividend, quotient;
   logic [tkd_pkg::DIVISOR_W-1:0] div_divisor, remainder;
   logic                          div_busy;

   always_comb begin
      cal_first = cal_count_ff == '0;
      cal_last  = ({1'b0, cal_count_ff} + (CCW+1)'(1)) >= (CCW+1)'(CAL_SAMPLES);
      cal_total = (cal_first ? '0 : cal_sum_ff) + CSW'(sense_ff);
      if (cmd.div_long) begin
         div_dividend = is_cal_ff ? tkd_pkg::DIV_W'(cal_total) : sum_ff;
      end else begin
         div_dividend = tkd_pkg::DIV_W'(round_eff_ff);
      end
      div_divisor = is_cal_ff ? tkd_pkg::DIVISOR_W'(CAL_SAMPLES) : period_eff;
   end

   tkd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .long_mode (cmd.div_long),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rec_ff    <= rec;
         sum_ff    <= sum_wide[SUMW] ? {SUMW{1'b1}} : sum_wide[SUMW-1:0];
         thr_ff    <= prod[PRODW-1:8];
         update_ff <= 1'b0;
      end else if (cmd.upd_capture) begin
         update_ff <= remainder == '0;
      end
   end

   // key update
   logic          above;
   logic [DW-1:0] deb_inc;
   logic [VW-1:0] avg;
   logic [EW-1:0] ev;

   always_comb begin
      above   = {1'b0, sense_ff} > thr_ff;
      deb_inc = (rec_ff.deb_count == {DW{1'b1}}) ? rec_ff.deb_count : rec_ff.deb_count + DW'(1);
      avg     = (quotient[tkd_pkg::DIV_W-1:VW] != '0) ? {VW{1'b1}} : quotient[VW-1:0];
      new_rec = rec_ff;
      ev      = tkd_pkg::EV_IDLE;
      if (is_cal_ff) begin
         if (cal_first) begin
            new_rec = '0;
         end
         if (cal_last) begin
            new_rec.base = quotient[VW-1:0];
            ev           = tkd_pkg::EV_CALIBRATED;
         end
      end else begin
         new_rec.sum = update_ff ? '0 : sum_ff;
         case (rec_ff.phase)
            PH_IDLE: begin
               if (above) begin
                  if (deb_inc > debounce_limit_ff) begin
                     new_rec.deb_count = '0;
                     new_rec.phase     = PH_TOUCHED;
                     ev                = tkd_pkg::EV_TOUCH;
                  end else begin
                     new_rec.deb_count = deb_inc;
                  end
               end else begin
                  if (update_ff && (avg > rec_ff.base)) begin
                     new_rec.base = rec_ff.base + VW'(1);
                  end else if (update_ff && (avg < rec_ff.base)) begin
                     new_rec.base = rec_ff.base - VW'(1);
                  end
                  new_rec.deb_count = '0;
               end
            end
            PH_TOUCHED: begin
               ev = tkd_pkg::EV_TOUCHED;
               if (above) begin
                  new_rec.deb_count = '0;
               end else if (deb_inc > debounce_limit_ff) begin
                  new_rec.deb_count = '0;
                  new_rec.phase     = PH_RELEASED;
                  ev                = tkd_pkg::EV_RELEASE;
               end else begin
                  new_rec.deb_count = deb_inc;
               end
            end
            PH_RELEASED: begin
               ev = tkd_pkg::EV_RELEASED;
               if (deb_inc > DW'(RELEASE_HOLD)) begin
                  new_rec.deb_count = '0;
                  new_rec.phase     = PH_IDLE;
                  ev                = tkd_pkg::EV_IDLE;
               end else begin
                  new_rec.deb_count = deb_inc;
               end
            end
            default: begin
               new_rec.phase = PH_IDLE;
            end
         endcase
      end
   end

   assign wr_en = cmd.commit && !tmo_ff;

   logic [7:0]    key_nxt;
   logic          key_wrap;
   logic [KW-1:0] key_next;

   always_comb begin
      key_nxt  = 8'(key_ff) + 8'd1;
      key_wrap = key_nxt >= kc;
      key_next = key_wrap ? '0 : KW'(key_nxt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_key_ff  <= '0;
         round_ff     <= '0;
         cal_key_ff   <= '0;
         cal_count_ff <= '0;
         cal_sum_ff   <= '0;
         valid_ff     <= '0;
      end else if (wr_en) begin
         valid_ff[key_ff] <= 1'b1;
         if (is_cal_ff) begin
            cal_key_ff   <= cal_last ? key_next : key_ff;
            cal_count_ff <= cal_last ? '0 : cal_count_ff + CCW'(1);
            cal_sum_ff   <= cal_last ? '0 : cal_total;
         end else begin
            scan_key_ff <= key_next;
            round_ff    <= key_wrap ? round_eff_ff + RW'(1) : round_eff_ff;
         end
      end
   end

   // result register
   logic                       rsp_valid_ff;
   logic [EW-1:0]              ev_ff;
   logic [tkd_pkg::KEY_ID_W-1:0] key_id_ff;
   logic [VW-1:0]              out_sense_ff, out_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         ev_ff        <= tmo_ff ? tkd_pkg::EV_TIMEOUT : ev;
         key_id_ff    <= tkd_pkg::KEY_ID_W'(key_ff);
         out_sense_ff <= tmo_ff ? '0 : sense_ff;
         out_base_ff  <= tmo_ff ? rec_ff.base : new_rec.base;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = ev_ff;
   assign rsp_tdata  = {{(tkd_pkg::RSP_DATA_W - tkd_pkg::KEY_ID_W - 2*VW){1'b0}},
                        out_base_ff, out_sense_ff, key_id_ff};

   always_comb begin
      sts          = '0;
      sts.is_cal   = is_cal_ff;
      sts.tmo      = tmo_ff;
      sts.cal_last = cal_last;
      sts.div_busy = div_busy;
      sts.rem_zero = remainder == '0;
      sts.out_free = !rsp_valid_ff || rsp_tready;
   end

endmodule

// ----- rtl/touch_key_detector.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata: raw_count; tuser: command, self_mode, timed_out
// rsp      out        rsp_tvalid/rsp_tready  tdata: key_id, sense_value, baseline; tuser: event_res
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One request at a time: a timed-out sample skips the divider, a detect sample runs it
// once, or twice in a round that updates the baseline; the last calibration sample once.
// The divider is bit-serial (one quotient bit per cycle).
// Reset is synchronous; it clears the key table through per-key valid bits at once.
// A result held in the output register does not block the next request, but the
// following result waits until the held one is taken.
module touch_key_detector #(
   parameter int MAX_KEYS     = tkd_pkg::MAX_KEYS_DEF,
   parameter int CAL_SAMPLES  = tkd_pkg::CAL_SAMPLES_DEF,
   parameter int RELEASE_HOLD = tkd_pkg::RELEASE_HOLD_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tkd_pkg::REQ_DATA_W-1:0]  req_tdata,   // raw_count
   input  logic [tkd_pkg::REQ_USER_W-1:0]  req_tuser,   // command, self_mode, timed_out
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tkd_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // key_id, sense_value, baseline, pad
   output logic [tkd_pkg::RSP_USER_W-1:0]  rsp_tuser,   // event_res
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tkd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tkd_pkg::CSR_DATA_W-1:0]  csr_data
);

   tkd_pkg::cmd_type cmd;
   tkd_pkg::sts_type sts;

   tkd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tkd_dp #(
      .MAX_KEYS     (MAX_KEYS),
      .CAL_SAMPLES  (CAL_SAMPLES),
      .RELEASE_HOLD (RELEASE_HOLD)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule

// ----- rtl/tkd_checker.sv -----
module tkd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [tkd_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic [tkd_pkg::REQ_USER_W-1:0]  req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tkd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [tkd_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [tkd_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [tkd_pkg::CSR_DATA_W-1:0]  csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   a_timeout_sense: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tkd_pkg::EV_TIMEOUT) |-> rsp_tdata[19:4] == '0)
      else $error("timeout response carries a sense value");

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= tkd_pkg::EV_CALIBRATED)
      else $error("response event out of range");

endmodule

bind touch_key_detector tkd_checker u_tkd_checker (.*);
